// ----- rtl/uart_frame_receiver_crc32_assert.svh -----
// assertion macros shared by the frame receiver rtl
`ifndef UART_FRAME_RECEIVER_CRC32_ASSERT_SVH
`define UART_FRAME_RECEIVER_CRC32_ASSERT_SVH

// same-cycle implication, checked out of reset
`define UFRC_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define UFRC_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/ufrc_pkg.sv -----
// shared types, constants and crc function for the frame receiver
`timescale 1ns / 1ps
`default_nettype none

package ufrc_pkg;

  localparam int unsigned MaxPayload   = 128;
  localparam logic [31:0] CrcPoly      = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit      = 32'hFFFF_FFFF;
  localparam logic [7:0]  SofFirst     = 8'hA5;
  localparam logic [7:0]  SofSecond    = 8'h5A;
  localparam logic [31:0] TimeoutReset = 32'd10_000_000;

  // end status codes
  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  // result kind codes
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // request kind codes
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pbyte;
    logic [6:0]  pidx;
    logic [7:0]  ftype;
    logic [15:0] fseq;
    logic [7:0]  flen;
    logic [1:0]  status;
  } ufrc_result_t;

  // reflected crc-32, one byte, unrolled into xor logic
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = {1'b0, c[31:1]} ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/uart_frame_receiver_crc32.sv -----
// Frame receiver: hunts for A5 5A, parses header, streams payload, checks CRC-32.
// A request is held in the input register, then its result, if any, in the output register that drives out_*.
// Throughput: one request per cycle while out_* is not stalled; set by the single pass through the header/crc logic.
// A request is taken whenever the input register is empty or moves on in that cycle.
// Reset (rst_n low, synchronous) empties both registers, restarts the hunt
// and sets the timeout limit to 10000000.
`timescale 1ns / 1ps
`default_nettype none

module uart_frame_receiver_crc32 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [7:0] payload_byte, [14:8] payload_index,
                                       // [22:15] frame_type, [38:23] frame_sequence,
                                       // [46:39] frame_length, [48:47] end_status,
                                       // [55:49] zero
  output logic             out_tuser,  // [0] out_kind
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  import ufrc_pkg::*;

  `include "uart_frame_receiver_crc32_assert.svh"

  logic         stg_valid_r;
  logic         stg_kind_r;
  logic [7:0]   stg_byte_r;
  logic         out_valid_r;
  ufrc_result_t out_res_r;

  logic         step;
  logic         res_valid;
  ufrc_result_t res;

  // the request in the input register moves on once the result slot is free
  assign step      = stg_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || step;
  assign cfg_ready = 1'b1;

  ufrc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .step      (step),
    .kind      (stg_kind_r),
    .data_byte (stg_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_kind_r <= in_tuser;
      stg_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {7'd0, out_res_r.status, out_res_r.flen, out_res_r.fseq,
                       out_res_r.ftype, out_res_r.pidx, out_res_r.pbyte};

  `UFRC_ASSERT_NXT(a_stall_holds, clk, rst_n, !in_tready, stg_valid_r,
                   "input register dropped a request while stalled")
  `UFRC_ASSERT_IMP(a_payload_status, clk, rst_n, out_tvalid && out_tuser == KIND_PAYLOAD,
                   out_tdata[48:47] == ST_VALID && out_tdata[46:39] != 8'd0,
                   "payload result with end status or zero length")
  `UFRC_ASSERT_IMP(a_end_clean, clk, rst_n, out_tvalid && out_tuser == KIND_END,
                   out_tdata[14:0] == 15'd0 && out_tdata[48:47] != 2'd3,
                   "end result carries payload data or bad status")

endmodule

`default_nettype wire

// ----- rtl/ufrc_core.sv -----
// frame state, crc check, timeout and result generation for one request
`timescale 1ns / 1ps
`default_nettype none

module ufrc_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [31:0]           cfg_data,
  input  wire logic                  step,
  input  wire logic                  kind,
  input  wire logic [7:0]            data_byte,
  output logic                       res_valid,
  output ufrc_pkg::ufrc_result_t     res
);
  import ufrc_pkg::*;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_TYPE    = 3'd1;
  localparam logic [2:0] PH_SEQ_LO  = 3'd2;
  localparam logic [2:0] PH_SEQ_HI  = 3'd3;
  localparam logic [2:0] PH_LEN_LO  = 3'd4;
  localparam logic [2:0] PH_LEN_HI  = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_CRC     = 3'd7;

  localparam logic [7:0] MaxLen = 8'(MaxPayload);

  logic [2:0]  phase_r,   phase_nxt;
  logic [7:0]  prev_r,    prev_nxt;
  logic [7:0]  type_r,    type_nxt;
  logic [15:0] seq_r,     seq_nxt;
  logic [7:0]  len_r,     len_nxt;
  logic [7:0]  cnt_r,     cnt_nxt;
  logic [31:0] crc_r,     crc_nxt;
  logic [23:0] rx_r,      rx_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [31:0] timeout_r;

  logic [31:0] crc_upd;
  logic [31:0] elapsed_inc;
  logic [31:0] limit;
  logic [7:0]  cnt_inc;
  logic        restart;

  assign crc_upd     = crc32_byte(crc_r, data_byte);
  assign elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + 32'd1;
  assign limit       = (timeout_r == 32'd0) ? 32'd1 : timeout_r;
  assign cnt_inc     = cnt_r + 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    prev_nxt    = prev_r;
    type_nxt    = type_r;
    seq_nxt     = seq_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    crc_nxt     = crc_r;
    rx_nxt      = rx_r;
    elapsed_nxt = elapsed_r;
    restart     = 1'b0;

    res_valid  = 1'b0;
    res.kind   = KIND_PAYLOAD;
    res.pbyte  = 8'd0;
    res.pidx   = 7'd0;
    res.ftype  = type_r;
    res.fseq   = seq_r;
    res.flen   = 8'd0;
    res.status = ST_VALID;

    if (kind == REQ_TICK) begin
      elapsed_nxt = elapsed_inc;
      if (elapsed_inc >= limit) begin
        restart    = 1'b1;
        res.status = ST_TIMEOUT;
      end
    end else begin
      unique case (phase_r)
        PH_TYPE: begin
          type_nxt  = data_byte;
          crc_nxt   = crc_upd;
          phase_nxt = PH_SEQ_LO;
        end
        PH_SEQ_LO: begin
          seq_nxt   = {8'd0, data_byte};
          crc_nxt   = crc_upd;
          phase_nxt = PH_SEQ_HI;
        end
        PH_SEQ_HI: begin
          seq_nxt   = {data_byte, seq_r[7:0]};
          crc_nxt   = crc_upd;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt   = data_byte;
          crc_nxt   = crc_upd;
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          crc_nxt = crc_upd;
          cnt_nxt = 8'd0;
          if (data_byte != 8'd0 || len_r > MaxLen) begin
            restart    = 1'b1;
            res.status = ST_INVALID;
          end else begin
            phase_nxt = (len_r == 8'd0) ? PH_CRC : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_nxt   = crc_upd;
          res_valid = 1'b1;
          res.pbyte = data_byte;
          res.pidx  = cnt_r[6:0];
          res.flen  = len_r;
          if (cnt_inc >= len_r) begin
            cnt_nxt   = 8'd0;
            phase_nxt = PH_CRC;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_CRC: begin
          // little-endian crc shifts in from the top
          rx_nxt = {data_byte, rx_r[23:8]};
          if (cnt_r[1:0] == 2'd3) begin
            restart    = 1'b1;
            res.status = ({data_byte, rx_r} == ~crc_r) ? ST_VALID : ST_INVALID;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        default: begin
          if (prev_r == SofFirst && data_byte == SofSecond) begin
            phase_nxt = PH_TYPE;
            crc_nxt   = CrcInit;
          end else begin
            phase_nxt = PH_HUNT;
            prev_nxt  = data_byte;
          end
        end
      endcase
    end

    if (restart) begin
      res_valid   = 1'b1;
      res.kind    = KIND_END;
      res.pbyte   = 8'd0;
      res.pidx    = 7'd0;
      res.flen    = (phase_r == PH_PAYLOAD || phase_r == PH_CRC) ? len_r : 8'd0;
      phase_nxt   = PH_HUNT;
      prev_nxt    = 8'd0;
      type_nxt    = 8'd0;
      seq_nxt     = 16'd0;
      len_nxt     = 8'd0;
      cnt_nxt     = 8'd0;
      crc_nxt     = CrcInit;
      rx_nxt      = 24'd0;
      elapsed_nxt = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      prev_r    <= 8'd0;
      type_r    <= 8'd0;
      seq_r     <= 16'd0;
      len_r     <= 8'd0;
      cnt_r     <= 8'd0;
      crc_r     <= CrcInit;
      rx_r      <= 24'd0;
      elapsed_r <= 32'd0;
      timeout_r <= TimeoutReset;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_data;
      end
      if (step) begin
        phase_r   <= phase_nxt;
        prev_r    <= prev_nxt;
        type_r    <= type_nxt;
        seq_r     <= seq_nxt;
        len_r     <= len_nxt;
        cnt_r     <= cnt_nxt;
        crc_r     <= crc_nxt;
        rx_r      <= rx_nxt;
        elapsed_r <= elapsed_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/uart_frame_receiver_crc32_check.sv -----
// frame receiver checker: mirrors the parser on accepted requests and compares every result
`timescale 1ns / 1ps

module uart_frame_receiver_crc32_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,  // [7:0] payload_byte, [14:8] payload_index,
                                  // [22:15] frame_type, [38:23] frame_sequence,
                                  // [46:39] frame_length, [48:47] end_status
  input  logic        out_tuser,  // [0] out_kind
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned results_pending
);
  import ufrc_pkg::*;

  typedef enum logic [3:0] {
    PS_HUNT, PS_TYPE, PS_SEQ_LO, PS_SEQ_HI, PS_LEN_LO, PS_LEN_HI, PS_PAYLOAD, PS_CRC
  } parse_state_t;

  parse_state_t pstate;
  logic [7:0]   prev_byte, hdr_type, hdr_len, byte_cnt;
  logic [15:0]  hdr_seq;
  logic [31:0]  crc_acc, crc_rx, ticks_seen, timeout_limit;
  ufrc_result_t awaited[$];
  int unsigned  fail_count = 0;
  int unsigned  awaited_count = 0;

  assign mismatches      = fail_count;
  assign results_pending = awaited_count;

  // bit-serial reflected crc, data bits taken lsb first
  function automatic logic [31:0] crc32_feed(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) r = (r >> 1) ^ ((r[0] ^ b[i]) ? CrcPoly : 32'd0);
    return r;
  endfunction

  task automatic restart_hunt_state();
    pstate     = PS_HUNT;
    prev_byte  = '0;
    hdr_type   = '0;
    hdr_seq    = '0;
    hdr_len    = '0;
    byte_cnt   = '0;
    crc_acc    = CrcInit;
    crc_rx     = '0;
    ticks_seen = '0;
  endtask

  task automatic close_frame(input logic [1:0] status);
    ufrc_result_t r;
    r        = '0;
    r.kind   = KIND_END;
    r.ftype  = hdr_type;
    r.fseq   = hdr_seq;
    // length only reported once it got past the length check
    r.flen   = (pstate == PS_PAYLOAD || pstate == PS_CRC) ? hdr_len : 8'd0;
    r.status = status;
    awaited.push_back(r);
    restart_hunt_state();
  endtask

  task automatic parse_request(input logic k, input logic [7:0] b);
    ufrc_result_t r;
    logic [31:0]  limit;
    if (k == REQ_TICK) begin
      limit = (timeout_limit == 0) ? 32'd1 : timeout_limit;
      if (ticks_seen != 32'hFFFF_FFFF) ticks_seen++;
      if (ticks_seen >= limit) close_frame(ST_TIMEOUT);
    end else begin
      case (pstate)
        PS_TYPE: begin
          hdr_type = b;
          crc_acc  = crc32_feed(crc_acc, b);
          pstate   = PS_SEQ_LO;
        end
        PS_SEQ_LO: begin
          hdr_seq = {8'd0, b};
          crc_acc = crc32_feed(crc_acc, b);
          pstate  = PS_SEQ_HI;
        end
        PS_SEQ_HI: begin
          hdr_seq[15:8] = b;
          crc_acc       = crc32_feed(crc_acc, b);
          pstate        = PS_LEN_LO;
        end
        PS_LEN_LO: begin
          hdr_len = b;
          crc_acc = crc32_feed(crc_acc, b);
          pstate  = PS_LEN_HI;
        end
        PS_LEN_HI: begin
          crc_acc = crc32_feed(crc_acc, b);
          if (b != 0 || hdr_len > MaxPayload) begin
            close_frame(ST_INVALID);
          end else begin
            byte_cnt = '0;
            pstate   = (hdr_len == 0) ? PS_CRC : PS_PAYLOAD;
          end
        end
        PS_PAYLOAD: begin
          r        = '0;
          r.kind   = KIND_PAYLOAD;
          r.pbyte  = b;
          r.pidx   = byte_cnt[6:0];
          r.ftype  = hdr_type;
          r.fseq   = hdr_seq;
          r.flen   = hdr_len;
          r.status = ST_VALID;
          awaited.push_back(r);
          crc_acc  = crc32_feed(crc_acc, b);
          byte_cnt++;
          if (byte_cnt >= hdr_len) begin
            byte_cnt = '0;
            pstate   = PS_CRC;
          end
        end
        PS_CRC: begin
          crc_rx = crc_rx | (32'(b) << (8 * byte_cnt[1:0]));
          if (byte_cnt[1:0] == 2'd3) close_frame((crc_rx == ~crc_acc) ? ST_VALID : ST_INVALID);
          else byte_cnt++;
        end
        default: begin
          if (prev_byte == SofFirst && b == SofSecond) begin
            pstate  = PS_TYPE;
            crc_acc = CrcInit;
          end else begin
            prev_byte = b;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    ufrc_result_t got, want;
    logic bad;
    if (!rst_n) begin
      restart_hunt_state();
      timeout_limit = TimeoutReset;
      awaited.delete();
    end else begin
      // a result passes the input and output registers after its request is accepted, so pop before push
      if (out_tvalid && out_tready) begin
        got.kind   = out_tuser;
        got.pbyte  = out_tdata[7:0];
        got.pidx   = out_tdata[14:8];
        got.ftype  = out_tdata[22:15];
        got.fseq   = out_tdata[38:23];
        got.flen   = out_tdata[46:39];
        got.status = out_tdata[48:47];
        if (awaited.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with nothing awaited: kind=%0d data=%h",
                     $time, got.kind, out_tdata);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          bad = (got.kind !== want.kind) || (got.pbyte !== want.pbyte) ||
                (got.pidx !== want.pidx) || (got.ftype !== want.ftype) ||
                (got.fseq !== want.fseq) || (got.flen !== want.flen) ||
                (got.status !== want.status);
          if (bad) begin
            if (fail_count < 10) begin
              $display("%0t: exp kind=%0d byte=%h idx=%0d type=%h seq=%h len=%0d status=%0d",
                       $time, want.kind, want.pbyte, want.pidx, want.ftype, want.fseq,
                       want.flen, want.status);
              $display("%0t: got kind=%0d byte=%h idx=%0d type=%h seq=%h len=%0d status=%0d",
                       $time, got.kind, got.pbyte, got.pidx, got.ftype, got.fseq,
                       got.flen, got.status);
            end
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) timeout_limit = cfg_data;
      if (in_tvalid && in_tready) parse_request(in_tuser, in_tdata);
    end
    awaited_count <= awaited.size();
  end

endmodule

// ----- tb/uart_frame_receiver_crc32_tb.sv -----
// frame receiver testbench top: clock, reset, request and config stimulus, back-pressure, verdict
`timescale 1ns / 1ps

module uart_frame_receiver_crc32_tb;
  import ufrc_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 300;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_SPARSE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] data_byte
  logic        in_tuser = 1'b0; // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;       // [7:0] payload_byte ... [48:47] end_status
  logic        out_tuser;       // [0] out_kind
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  int unsigned mismatches, results_pending;
  int          requests_sent = 0;
  int          burst_left = 0;
  int          quiet_cycles = 0;
  int          hold_cnt = 0;
  int          mode_left = 0;
  bit          no_gaps = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  rx_mode_t    rx_mode = RX_FREE;
  logic [1:0]  rx_beat = '0;

  uart_frame_receiver_crc32 u_dut (.*);

  uart_frame_receiver_crc32_check u_frame_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one long hold-off when asked, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt + 1;
      if (hold_cnt == HoldCycles) hold_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 2));
        mode_left <= $urandom_range(20, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      rx_beat <= rx_beat + 1'b1;
      case (rx_mode)
        RX_FREE:   out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 99) < 55);
        default:   out_tready <= (rx_beat == 2'd0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("uart_frame_receiver_crc32_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_request(input logic k, input logic [7:0] b);
    int gap;
    if (burst_left == 0 && !no_gaps) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  // drop valid and wait until every result is out and the pipeline has drained
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] fseq,
                            input logic [15:0] flen, input bit bad_crc,
                            input int cut_at, input int tick_pct);
    logic [7:0]  fb[$];
    logic [31:0] acc;
    fb = {SofFirst, SofSecond, ftype, fseq[7:0], fseq[15:8], flen[7:0], flen[15:8]};
    if (flen <= MaxPayload) begin
      repeat (flen) fb.push_back(8'($urandom_range(0, 255)));
      acc = CrcInit;
      // everything after the start pair goes into the crc
      for (int j = 2; j < fb.size(); j++)
        for (int i = 0; i < 8; i++)
          acc = (acc >> 1) ^ ((acc[0] ^ fb[j][i]) ? CrcPoly : 32'd0);
      acc = ~acc;
      if (bad_crc) acc = acc ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) fb.push_back(acc[8*i +: 8]);
    end
    if (cut_at > 0 && cut_at < fb.size()) fb = fb[0:cut_at-1];
    for (int k = 0; k < fb.size(); k++) begin
      while ($urandom_range(0, 99) < tick_pct)
        push_request(REQ_TICK, 8'($urandom_range(0, 255)));
      push_request(REQ_BYTE, fb[k]);
    end
  endtask

  // mostly well-formed frames, some noise, bad lengths, bad crcs and cut frames
  task automatic random_traffic(input int upto, input int tick_pct);
    int          r;
    logic [15:0] flen;
    while (requests_sent < upto) begin
      r = $urandom_range(0, 99);
      repeat ($urandom_range(0, 3))
        push_request(REQ_BYTE, (r < 15) ? SofFirst : 8'($urandom_range(0, 255)));
      if (r < 2) flen = 16'd128;
      else if (r < 8) flen = 16'($urandom_range(129, 255));
      else if (r < 11) flen = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
      else if (r < 25) flen = 16'($urandom_range(13, 40));
      else flen = 16'($urandom_range(0, 12));
      send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), flen,
                 $urandom_range(0, 99) < 12,
                 ($urandom_range(0, 99) < 5) ? $urandom_range(1, 12) : 0, tick_pct);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty frame with an all-ones header, then a high length byte and a length one too big
    send_frame(8'hFF, 16'hFFFF, 16'h0000, 1'b0, 0, 0);
    send_frame(8'h00, 16'h0000, 16'h0100, 1'b0, 0, 0);
    send_frame(8'h01, 16'h1234, 16'h0081, 1'b0, 0, 0);

    // keep offering payload while the receiver holds off, so the input stalls
    hold_req <= 1'b1;
    no_gaps = 1'b1;
    send_frame(8'h3C, 16'h0102, 16'd64, 1'b0, 0, 0);
    no_gaps = 1'b0;
    random_traffic(350, 5);

    settle();
    write_timeout(32'hFFFF_FFFF);
    random_traffic(450, 10);

    // zero timeout behaves as one: every tick ends the attempt, hunting included
    settle();
    write_timeout(32'd0);
    push_request(REQ_TICK, 8'h00);
    push_request(REQ_BYTE, SofFirst);
    push_request(REQ_BYTE, SofSecond);
    push_request(REQ_TICK, 8'hFF);
    random_traffic(520, 3);

    settle();
    write_timeout(32'd1);
    random_traffic(560, 2);

    settle();
    write_timeout(32'd40);
    random_traffic(880, 4);

    // back to hunting, then lower the timeout in the middle of a payload
    settle();
    write_timeout(32'd1);
    push_request(REQ_TICK, 8'h5A);
    settle();
    write_timeout(32'd1000);
    send_frame(8'h77, 16'hBEEF, 16'd5, 1'b0, 9, 0);
    repeat (20) push_request(REQ_TICK, 8'($urandom_range(0, 255)));
    settle();
    write_timeout(32'd5);
    push_request(REQ_TICK, 8'h00);

    settle();
    write_timeout(32'd3);
    random_traffic(1080, 6);

    settle();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && results_pending == 0) begin
      $display("uart_frame_receiver_crc32_tb: clean");
    end else begin
      $display("uart_frame_receiver_crc32_tb: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ufrc_pkg.sv
rtl/ufrc_core.sv
rtl/uart_frame_receiver_crc32.sv
tb/uart_frame_receiver_crc32_check.sv
tb/uart_frame_receiver_crc32_tb.sv
